FILE: hw/rtl/mhti_pkg.sv
`default_nettype none

package mhti_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int MAC_W           = 48;
   localparam int SUM_W           = 9;
   localparam int STATUS_W        = 2;
   localparam int SLOT_IDX_W      = 4;
   localparam int RECIP_SHIFT     = 20;
   localparam int ENTRY_W         = MAC_W + 1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_CHECK
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mhti_home_slot.sv
`default_nettype none

module mhti_home_slot #(
   parameter int TABLE_SLOTS = mhti_pkg::TABLE_SLOTS_DEF,
   parameter int IDX_W       = $clog2(TABLE_SLOTS)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [mhti_pkg::SUM_W-1:0] sum,
   output logic                            done,
   output logic [IDX_W-1:0]                slot
);

   localparam int SHIFT  = mhti_pkg::RECIP_SHIFT;
   localparam int PROD_W = mhti_pkg::SUM_W + SHIFT;
   localparam int DIV_W  = $clog2(TABLE_SLOTS + 1);
   localparam int BACK_W = mhti_pkg::SUM_W + DIV_W;
   localparam logic [SHIFT-1:0] RECIP =
      SHIFT'((2 ** SHIFT + TABLE_SLOTS - 1) / TABLE_SLOTS);

   logic [mhti_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [mhti_pkg::SUM_W-1:0] quot_ff, quot_in;
   logic [mhti_pkg::SUM_W-1:0] rem_ff, rem_in;
   logic                       qstep_ff, qstep_in;
   logic                       rstep_ff, rstep_in;
   logic                       done_ff, done_in;
   logic [PROD_W-1:0]          prod;
   logic [BACK_W-1:0]          back;

   // quotient by reciprocal multiply, then remainder by multiply back and subtract
   always_comb begin
      prod     = PROD_W'(sum_ff) * PROD_W'(RECIP);
      back     = BACK_W'(quot_ff) * BACK_W'(TABLE_SLOTS);
      sum_in   = sum_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      qstep_in = 1'b0;
      rstep_in = 1'b0;
      done_in  = 1'b0;
      if (start) begin
         sum_in   = sum;
         qstep_in = 1'b1;
      end else if (qstep_ff) begin
         quot_in  = prod[PROD_W-1:SHIFT];
         rstep_in = 1'b1;
      end else if (rstep_ff) begin
         rem_in  = mhti_pkg::SUM_W'(BACK_W'(sum_ff) - back);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qstep_ff <= 1'b0;
         rstep_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         qstep_ff <= qstep_in;
         rstep_ff <= rstep_in;
         done_ff  <= done_in;
      end
      sum_ff  <= sum_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign slot = IDX_W'(rem_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/mhti_entry_ram.sv
`default_nettype none

module mhti_entry_ram #(
   parameter int TABLE_SLOTS = mhti_pkg::TABLE_SLOTS_DEF,
   parameter int IDX_W       = $clog2(TABLE_SLOTS)
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [IDX_W-1:0]             rd_addr,
   output logic [mhti_pkg::ENTRY_W-1:0]      rd_data,
   input  wire logic                         wr_en,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire logic [mhti_pkg::ENTRY_W-1:0] wr_data
);

   logic [mhti_pkg::ENTRY_W-1:0] mem_ff [TABLE_SLOTS];
   logic [mhti_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mac_hash_table_insert_top.sv
// flow: a taken request passes through the home slot reduction, then probes the table
//    slot by slot from the home slot, up to TABLE_SLOTS probes; a held response delays the last probe
// requests: one item at a time; a new request is taken only once the previous response is
//    registered, with one table read per probe on the entry memory's single read port
// reset: synchronous, clears control state, then a clearing pass writes every slot
//    empty while no request is taken
`default_nettype none

module mac_hash_table_insert_top #(
   parameter int TABLE_SLOTS = mhti_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [mhti_pkg::MAC_W-1:0]        req_mac_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [mhti_pkg::STATUS_W-1:0]          rsp_status,
   output logic [mhti_pkg::SLOT_IDX_W-1:0]        rsp_slot_index
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

   mhti_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]                   pos_ff, pos_in;
   logic [IDX_W-1:0]                   cnt_ff, cnt_in;
   logic [IDX_W-1:0]                   clr_ff, clr_in;
   logic [mhti_pkg::MAC_W-1:0]         mac_ff, mac_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mhti_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [mhti_pkg::SLOT_IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic                               hash_start;
   logic [mhti_pkg::SUM_W-1:0]         hash_sum;
   logic                               hash_done;
   logic [IDX_W-1:0]                   hash_slot;

   logic                               rd_en;
   logic [IDX_W-1:0]                   rd_addr;
   logic [mhti_pkg::ENTRY_W-1:0]       rd_data;
   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic [mhti_pkg::ENTRY_W-1:0]       wr_data;

   logic                               out_free;
   logic                               ent_valid;
   logic                               ent_match;
   logic [IDX_W-1:0]                   pos_next;

   mhti_home_slot #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_home_slot (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .sum   (hash_sum),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   mhti_entry_ram #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign hash_sum  = mhti_pkg::SUM_W'(req_mac_address[47:40]) +
                      mhti_pkg::SUM_W'(req_mac_address[7:0]);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ent_valid = rd_data[mhti_pkg::ENTRY_W-1];
   assign ent_match = (rd_data[mhti_pkg::MAC_W-1:0] == mac_ff);
   assign pos_next  = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      mac_in        = mac_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = (state_ff != mhti_pkg::S_IDLE);
      hash_start    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {1'b1, mac_ff};

      case (state_ff)
         mhti_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = mhti_pkg::S_IDLE;
            end
         end
         mhti_pkg::S_IDLE: begin
            if (req_valid) begin
               mac_in     = req_mac_address;
               hash_start = 1'b1;
               state_in   = mhti_pkg::S_HASH;
            end
         end
         mhti_pkg::S_HASH: begin
            if (hash_done) begin
               rd_en    = 1'b1;
               rd_addr  = hash_slot;
               pos_in   = hash_slot;
               cnt_in   = '0;
               state_in = mhti_pkg::S_CHECK;
            end
         end
         mhti_pkg::S_CHECK: begin
            if (!ent_valid) begin
               if (out_free) begin
                  wr_en         = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mhti_pkg::ST_INSERTED;
                  rsp_slot_in   = mhti_pkg::SLOT_IDX_W'(pos_ff);
                  state_in      = mhti_pkg::S_IDLE;
               end
            end else if (ent_match) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mhti_pkg::ST_PRESENT;
                  rsp_slot_in   = mhti_pkg::SLOT_IDX_W'(pos_ff);
                  state_in      = mhti_pkg::S_IDLE;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mhti_pkg::ST_FULL;
                  rsp_slot_in   = '0;
                  state_in      = mhti_pkg::S_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos_next;
               pos_in  = pos_next;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = mhti_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhti_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      mac_ff        <= mac_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

`default_nettype wire
